[rtl/core/pin_follower_change_scanner_core_defines.svh]
// Assertion macros used by the checker file of the pin follower change scanner.
`ifndef PIN_FOLLOWER_CHANGE_SCANNER_CORE_DEFINES_SVH
`define PIN_FOLLOWER_CHANGE_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PFCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pfcs_pkg.sv]
// Types, constants and helper functions of the pin follower change scanner.
`default_nettype none

package pfcs_pkg;

    localparam int NUM_PINS  = 30;
    localparam int NUM_PORTS = 4;
    localparam int PIN_W     = 5;
    localparam int PORT_W    = 2;
    localparam int BIT_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int MAP_DEPTH = NUM_PINS * NUM_PORTS;
    localparam int MAP_AW    = PIN_W + PORT_W;
    localparam int MAP_W     = 2 * BYTE_W;

    // Port 3 carries no pins on its two low bits; a scan forces them high.
    localparam logic [BYTE_W-1:0] GUARD_BITS       = 8'h03;
    localparam logic [PORT_W-1:0] GUARD_PORT       = 2'd3;
    localparam logic [BIT_W-1:0]  PORT3_BIT_OFFSET = 3'd2;

    typedef enum logic {
        CMD_BASELINE = 1'b0,
        CMD_SCAN     = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                command;
        logic [PIN_W-1:0]    driven_pin;
        logic [PORT_W-1:0]   port_index;
        logic [BYTE_W-1:0]   sample;
    } pfcs_in_t;

    typedef struct packed {
        logic [PIN_W-1:0]    source_pin;
        logic [PORT_W-1:0]   follower_port;
        logic [BIT_W-1:0]    follower_bit;
        logic                pressed;
        logic                last;
    } pfcs_out_t;

    // Port that a pin number lives on.
    function automatic logic [PORT_W-1:0] pin_home_port(input logic [PIN_W-1:0] pin);
        return pin[PIN_W-1:BIT_W];
    endfunction

    // Bit position of a pin within its port; port 3 starts at bit 2.
    function automatic logic [BIT_W-1:0] pin_bit(input logic [PIN_W-1:0] pin);
        logic [BIT_W-1:0] b;
        b = pin[BIT_W-1:0];
        if (pin_home_port(pin) == GUARD_PORT)
        begin
            b = b + PORT3_BIT_OFFSET;
        end
        return b;
    endfunction

    // True when the byte has no more than one bit set.
    function automatic logic at_most_one(input logic [BYTE_W-1:0] m);
        return (m & (m - 8'd1)) == '0;
    endfunction

    // True when the byte has no more than two bits set.
    function automatic logic at_most_two(input logic [BYTE_W-1:0] m);
        logic [BYTE_W-1:0] rest;
        rest = m & (m - 8'd1);
        return (rest & (rest - 8'd1)) == '0;
    endfunction

endpackage

`default_nettype wire

[rtl/core/pfcs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pfcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/pin_follower_change_scanner_core.sv]
// Top level of the pin follower change scanner: map lookup, change detect and event drain.
`default_nettype none

// A beat on the input side is one sampled port byte, accepted at a rising edge with start
// high and busy low. A baseline beat stores the byte for its (driven pin, port) pair and
// yields no events. A scan beat yields one event per pin whose follower status changed,
// lowest bit first, each on the result port for exactly one cycle with strobe high; the
// final event of a beat has last set. The first event of a beat reaches the result port
// after its map lookup and compare: the map read is registered on the edge that accepts
// the beat, the compare fills the following cycle, and the event drain register then
// takes the events. Events leave at one per cycle, so a beat occupies the result port for
// as long as it has events; beats that yield zero or one event can be given in every
// cycle. The event drain register sets the beat rate: busy rises only when the events
// still waiting would not be gone before the next beat's events arrive, so the block never
// drops an event and needs no stall from the receiver, which has none. Driven pins of 30
// and above are ignored entirely. The baseline and previous maps live in one memory of 120
// words and are not cleared at reset; a scan of a pair that never saw a baseline beat
// gives undefined events. There is no clearing pass after reset.
module pin_follower_change_scanner_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire pfcs_pkg::pfcs_in_t item,
    output logic                    strobe,
    output pfcs_pkg::pfcs_out_t     result
);

    import pfcs_pkg::*;

    logic                accept;
    logic [MAP_AW-1:0]   in_addr;

    // Lookup stage: the beat being compared against its map entry.
    logic                b_valid_reg;
    pfcs_in_t            b_item_reg;
    logic [MAP_W-1:0]    ram_rdata;
    logic [MAP_AW-1:0]   b_addr;
    logic                b_pin_ok;
    logic                b_we;
    logic [MAP_W-1:0]    b_entry;
    logic [BYTE_W-1:0]   b_base;
    logic [BYTE_W-1:0]   b_prev;
    logic [BYTE_W-1:0]   b_smp;
    logic [BYTE_W-1:0]   b_now;
    logic [BYTE_W-1:0]   b_own;
    logic [BYTE_W-1:0]   b_mask;
    logic [MAP_W-1:0]    b_wdata;

    // Bypass for a write that lands on the same edge as the next read.
    logic                fwd_valid_reg;
    logic [MAP_AW-1:0]   fwd_addr_reg;
    logic [MAP_W-1:0]    fwd_data_reg;

    // Event drain: pending change bits of the beat being reported.
    logic [BYTE_W-1:0]   e_mask_reg;
    logic [BYTE_W-1:0]   e_mask_next;
    logic [BYTE_W-1:0]   e_now_reg;
    logic [PIN_W-1:0]    e_pin_reg;
    logic [PORT_W-1:0]   e_port_reg;
    logic [BYTE_W-1:0]   e_rest;
    logic [BIT_W-1:0]    e_bit;

    assign accept  = start && !busy;
    assign in_addr = {item.driven_pin, item.port_index};

    pfcs_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_addr),
        .wdata (b_wdata),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Each map word holds the baseline byte above the previous sample byte.
    always_comb
    begin
        b_addr   = {b_item_reg.driven_pin, b_item_reg.port_index};
        b_pin_ok = b_item_reg.driven_pin < PIN_W'(NUM_PINS);
        b_we     = b_valid_reg && b_pin_ok;
        b_entry  = (fwd_valid_reg && fwd_addr_reg == b_addr) ? fwd_data_reg : ram_rdata;
        b_base   = b_entry[MAP_W-1:BYTE_W];
        b_prev   = b_entry[BYTE_W-1:0];
        b_smp    = b_item_reg.sample;
        if (b_item_reg.port_index == GUARD_PORT)
        begin
            b_smp = b_smp | GUARD_BITS;
        end
        b_now = b_base & ~b_smp;

        // The driven pin always reads low on its own port, so it is never reported.
        b_own = '0;
        if (b_item_reg.port_index == pin_home_port(b_item_reg.driven_pin))
        begin
            b_own = BYTE_W'(1) << pin_bit(b_item_reg.driven_pin);
        end

        b_mask  = '0;
        b_wdata = {b_base, b_smp};
        unique case (b_item_reg.command)
            CMD_BASELINE:
            begin
                b_wdata = {b_item_reg.sample, b_item_reg.sample};
            end
            CMD_SCAN:
            begin
                if (b_valid_reg && b_pin_ok)
                begin
                    b_mask = (b_now ^ (b_base & ~b_prev)) & ~b_own;
                end
            end
        endcase
    end

    // The drain never holds more than one bit when a new beat's events arrive.
    always_comb
    begin
        e_rest = e_mask_reg & (e_mask_reg - 8'd1);
        if (b_valid_reg)
        begin
            e_mask_next = b_mask;
        end
        else
        begin
            e_mask_next = e_rest;
        end

        e_bit = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (e_mask_reg[i])
            begin
                e_bit = BIT_W'(i);
            end
        end
    end

    // A beat taken now has its events loaded into the drain after its map lookup; the drain
    // must be down to one pending bit by then.
    assign busy = b_valid_reg ? !at_most_one(b_mask) : !at_most_two(e_mask_reg);

    assign strobe               = |e_mask_reg;
    assign result.source_pin    = e_pin_reg;
    assign result.follower_port = e_port_reg;
    assign result.follower_bit  = e_bit;
    assign result.pressed       = e_now_reg[e_bit];
    assign result.last          = e_rest == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            e_mask_reg    <= '0;
        end
        else
        begin
            b_valid_reg   <= accept;
            fwd_valid_reg <= b_we;
            e_mask_reg    <= e_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_item_reg <= item;
        end
        fwd_addr_reg <= b_addr;
        fwd_data_reg <= b_wdata;
        if (b_valid_reg)
        begin
            e_now_reg  <= b_now;
            e_pin_reg  <= b_item_reg.driven_pin;
            e_port_reg <= b_item_reg.port_index;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pfcs_checker.sv]
// Port-level checker for the pin follower change scanner and its bind to the top level.
`default_nettype none

`include "pin_follower_change_scanner_core_defines.svh"

module pfcs_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire pfcs_pkg::pfcs_in_t  item,
    input wire logic                strobe,
    input wire pfcs_pkg::pfcs_out_t result
);

    import pfcs_pkg::*;

    // A beat that can cause no events must leave the result port quiet when it drains.
    `PFCS_ASSERT_IMPL(a_quiet_beat, clk, rst_n, start && !busy && (item.command == CMD_BASELINE || item.driven_pin >= PIN_W'(NUM_PINS)), ##2 !strobe, "baseline or ignored beat produced an event")

    // Events of one beat leave back to back until the last one.
    `PFCS_ASSERT_NEXT(a_no_gap, clk, rst_n, strobe && !result.last, strobe, "event burst broke off before its last event")

    // All events of one beat carry the same driven pin and port.
    `PFCS_ASSERT_NEXT(a_same_src, clk, rst_n, strobe && !result.last, result.source_pin == $past(result.source_pin) && result.follower_port == $past(result.follower_port), "event burst changed its source")

    // Within a burst the bit number rises strictly.
    `PFCS_ASSERT_NEXT(a_bit_order, clk, rst_n, strobe && !result.last, result.follower_bit > $past(result.follower_bit), "events not in ascending bit order")

endmodule

bind pin_follower_change_scanner_core pfcs_checker u_pfcs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire
